// ----- rtl/cmc_pkg.sv -----
// ----------------------------------------------------------------------------
// cmc_pkg
// Shared types, constants and calendar helpers for the minute clock core.
// ----------------------------------------------------------------------------
package cmc_pkg;

    localparam logic [11:0] YEAR_MAX     = 12'd4095;
    localparam logic [11:0] VALID_YEAR   = 12'd2020;
    localparam logic [4:0]  HOUR_LAST    = 5'd23;
    localparam logic [5:0]  MINUTE_LAST  = 6'd59;
    localparam logic [3:0]  MONTH_LAST   = 4'd12;
    localparam logic [3:0]  MONTH_FEB    = 4'd2;
    localparam logic [3:0]  MONTH_MAR    = 4'd3;
    localparam logic [12:0] CYCLE_YEARS  = 13'd400;
    localparam logic [3:0]  WEEK_DAYS    = 4'd7;
    localparam logic [11:0] DIV25_MUL    = 12'd2622;  // ceil(2^16 / 25)
    localparam logic [11:0] DIV25_BASE   = 12'd25;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_SET  = 2'd1,
        OP_READ = 2'd2
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [11:0] set_year;
        logic [3:0]  set_month;
        logic [4:0]  set_day;
        logic [4:0]  set_hour;
        logic [5:0]  set_minute;
        logic [5:0]  set_second;
    } req_t;

    typedef struct packed {
        logic [11:0] cur_year;
        logic [3:0]  cur_month;
        logic [4:0]  cur_day;
        logic [4:0]  cur_hour;
        logic [5:0]  cur_minute;
        logic [5:0]  cur_second;
        logic [2:0]  day_of_week;
        logic        time_valid;
    } rsp_t;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } clock_t;

    // floor(x / 25) for x < 4096 by reciprocal multiply; exact over that range
    function automatic logic [7:0] div25(input logic [11:0] x);
        logic [23:0] prod;
        prod = {12'd0, x} * {12'd0, DIV25_MUL};
        return prod[23:16];
    endfunction

    function automatic logic is_leap(input logic [11:0] y);
        logic [7:0]  q;
        logic [11:0] back;
        logic        by25;
        q    = div25(y);
        back = {4'd0, q} * DIV25_BASE;
        by25 = (back == y);
        // div by 100 means div by 4 and 25; div by 400 adds div by 16
        return (y[1:0] == 2'd0) && (!by25 || (y[3:0] == 4'd0));
    endfunction

    // out-of-range months count as 31 days
    function automatic logic [4:0] month_days(input logic [11:0] y, input logic [3:0] m);
        logic [4:0] len;
        unique case (m)
            4'd2:                    len = is_leap(y) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

    // Sakamoto month offsets; out-of-range months use 0
    function automatic logic [2:0] wd_offset(input logic [3:0] m);
        logic [2:0] off;
        unique case (m)
            4'd2, 4'd6:  off = 3'd3;
            4'd3, 4'd11: off = 3'd2;
            4'd4:        off = 3'd5;
            4'd7:        off = 3'd5;
            4'd8:        off = 3'd1;
            4'd9, 4'd12: off = 3'd4;
            4'd10:       off = 3'd6;
            default:     off = 3'd0;
        endcase
        return off;
    endfunction

endpackage

// ----- rtl/calendar_minute_clock_core.sv -----
// ----------------------------------------------------------------------------
// calendar_minute_clock_core
// Pipeline: an accepted request updates the clock registers (stage 1), then
//          the response register (stage 2) loads it and rsp_valid rises.
// Throughput: one request per cycle while the response is not stalled.
// Reset (rst_n low, async): date 0000-01-01 00:00:00, pipeline emptied.
// ----------------------------------------------------------------------------
module calendar_minute_clock_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  cmc_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output cmc_pkg::rsp_t  rsp
);
    import cmc_pkg::*;

    // Stage 1: the clock registers themselves. An accepted transaction
    // updates them and marks stage 1 occupied.
    // Stage 2: the response register. It samples the clock registers after
    // the update once it is free, adds the weekday and the valid flag, and holds
    // until the consumer takes it. Because a later transaction only touches
    // the clock registers at the same edge that stage 2 samples them, each
    // response reflects exactly its own transaction.

    clock_t clk_reg;
    clock_t clk_next;
    logic   s1_valid_reg;
    logic   s1_valid_next;
    rsp_t   rsp_reg;
    rsp_t   rsp_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   req_fire;
    logic   s2_load;
    logic [2:0] wday;

    cmc_advance u_advance (
        .req (req),
        .cur (clk_reg),
        .nxt (clk_next)
    );

    cmc_weekday u_weekday (
        .year  (clk_reg.year),
        .month (clk_reg.month),
        .day   (clk_reg.day),
        .wday  (wday)
    );

    // stage 2 can take a new response when empty or being drained
    assign s2_load   = !rsp_valid_reg || rsp_ready;
    // stage 1 may refill when empty or when its transaction moves on
    assign req_ready = !s1_valid_reg || s2_load;
    assign req_fire  = req_valid && req_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (req_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s2_load)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (s2_load)
        begin
            rsp_valid_next = s1_valid_reg;
        end
        if (s2_load && s1_valid_reg)
        begin
            rsp_next.cur_year    = clk_reg.year;
            rsp_next.cur_month   = clk_reg.month;
            rsp_next.cur_day     = clk_reg.day;
            rsp_next.cur_hour    = clk_reg.hour;
            rsp_next.cur_minute  = clk_reg.minute;
            rsp_next.cur_second  = clk_reg.second;
            rsp_next.day_of_week = wday;
            // weekday is reported even when the time is flagged invalid
            rsp_next.time_valid  = (clk_reg.hour <= HOUR_LAST)
                                && (clk_reg.year >= VALID_YEAR);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clk_reg       <= '{year: 12'd0, month: 4'd1, day: 5'd1,
                               hour: 5'd0, minute: 6'd0, second: 6'd0};
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_fire)
            begin
                clk_reg <= clk_next;
            end
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // response payload carries no reset
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ----- rtl/cmc_advance.sv -----
// ----------------------------------------------------------------------------
// cmc_advance
// Next clock state for one transaction: minute tick with carries, load, or hold on read.
// ----------------------------------------------------------------------------
module cmc_advance (
    input  cmc_pkg::req_t   req,
    input  cmc_pkg::clock_t cur,
    output cmc_pkg::clock_t nxt
);
    import cmc_pkg::*;

    always_comb
    begin
        logic [6:0] min_inc;
        logic [5:0] hour_inc;
        logic [5:0] day_inc;
        logic [4:0] mon_inc;
        min_inc  = {1'b0, cur.minute} + 7'd1;
        hour_inc = {1'b0, cur.hour} + 6'd1;
        day_inc  = {1'b0, cur.day} + 6'd1;
        mon_inc  = {1'b0, cur.month} + 5'd1;
        nxt      = cur;
        unique case (req.op)
            OP_SET:
            begin
                nxt.year   = req.set_year;
                nxt.month  = req.set_month;
                nxt.day    = req.set_day;
                nxt.hour   = req.set_hour;
                nxt.minute = req.set_minute;
                nxt.second = req.set_second;
            end
            OP_TICK:
            begin
                // unknown hour freezes the clock
                if (cur.hour <= HOUR_LAST)
                begin
                    nxt.second = '0;
                    if (min_inc <= {1'b0, MINUTE_LAST})
                    begin
                        nxt.minute = min_inc[5:0];
                    end
                    else
                    begin
                        nxt.minute = '0;
                        if (hour_inc <= {1'b0, HOUR_LAST})
                        begin
                            nxt.hour = hour_inc[4:0];
                        end
                        else
                        begin
                            nxt.hour = '0;
                            if (day_inc <= {1'b0, month_days(cur.year, cur.month)})
                            begin
                                nxt.day = day_inc[4:0];
                            end
                            else
                            begin
                                nxt.day = 5'd1;
                                if (mon_inc <= {1'b0, MONTH_LAST})
                                begin
                                    nxt.month = mon_inc[3:0];
                                end
                                else
                                begin
                                    nxt.month = 4'd1;
                                    if (cur.year < YEAR_MAX)
                                    begin
                                        nxt.year = cur.year + 12'd1;
                                    end
                                end
                            end
                        end
                    end
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

// ----- rtl/cmc_weekday.sv -----
// ----------------------------------------------------------------------------
// cmc_weekday
// Sakamoto weekday of a date, 0 is Sunday; mod 7 by octal digit folding.
// ----------------------------------------------------------------------------
module cmc_weekday (
    input  logic [11:0] year,
    input  logic [3:0]  month,
    input  logic [4:0]  day,
    output logic [2:0]  wday
);
    import cmc_pkg::*;

    always_comb
    begin
        logic [12:0] yy;
        logic [2:0]  off;
        logic [10:0] q4;
        logic [7:0]  q100;
        logic [12:0] sum;
        logic [4:0]  f1;
        logic [3:0]  f2;
        logic [3:0]  f3;
        // +400 keeps year 0 well defined and leaves the weekday unchanged
        yy  = {1'b0, year} + CYCLE_YEARS;
        off = 3'd0;
        if ((month >= 4'd1) && (month <= MONTH_LAST))
        begin
            off = wd_offset(month);
            if (month < MONTH_MAR)
            begin
                yy = yy - 13'd1;
            end
        end
        q4   = yy[12:2];
        q100 = div25({1'b0, q4});        // floor(yy / 100)
        sum  = yy + {2'b0, q4} - {5'b0, q100} + {7'b0, q100[7:2]}
             + {10'b0, off} + {8'b0, day};
        // 8 = 1 mod 7: add octal digits, twice, then one correction
        f1   = {2'b0, sum[2:0]} + {2'b0, sum[5:3]} + {2'b0, sum[8:6]}
             + {2'b0, sum[11:9]} + {4'b0, sum[12]};
        f2   = {1'b0, f1[2:0]} + {2'b0, f1[4:3]};
        f3   = f2 - WEEK_DAYS;
        wday = (f2 >= WEEK_DAYS) ? f3[2:0] : f2[2:0];
    end

endmodule

// ----- rtl/cmc_checker.sv -----
// ----------------------------------------------------------------------------
// cmc_checker
// Port-level assertions for the minute clock core, bound to the top level.
// ----------------------------------------------------------------------------
module cmc_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input cmc_pkg::req_t req,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input cmc_pkg::rsp_t rsp
);
    import cmc_pkg::*;

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed or dropped while stalled");

    // only one transaction may be buffered behind a stalled response
    a_one_buffered: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready
        && $past(req_valid && req_ready && rsp_valid && !rsp_ready)
        |-> !req_ready)
        else $error("request taken with no room behind a stalled response");

    a_valid_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.time_valid
            == ((rsp.cur_hour <= HOUR_LAST) && (rsp.cur_year >= VALID_YEAR)))
        else $error("time_valid disagrees with reported hour and year");

    a_weekday_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.day_of_week != 3'd7)
        else $error("weekday out of range");

endmodule

bind calendar_minute_clock_core cmc_checker u_cmc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
